// ----- design/msc_pkg.sv -----
package msc_pkg;

   // Operation codes carried in a request transaction.
   localparam logic [2:0] OP_CPU_READ   = 3'd0;
   localparam logic [2:0] OP_CPU_WRITE  = 3'd1;
   localparam logic [2:0] OP_SNOOP_RD   = 3'd2;
   localparam logic [2:0] OP_SNOOP_WR   = 3'd3;
   localparam logic [2:0] OP_SNOOP_INV  = 3'd4;

   // Register reset value of the line limit.
   localparam int LIMIT_RESET = 8;

   // MESI line states.
   typedef enum logic [1:0] {
      ST_I = 2'd0,
      ST_S = 2'd1,
      ST_E = 2'd2,
      ST_M = 2'd3
   } line_state_type;

   // Bus actions reported with a result.
   typedef enum logic [1:0] {
      BUS_NONE  = 2'd0,
      BUS_RDMISS = 2'd1,
      BUS_WRMISS = 2'd2,
      BUS_INV   = 2'd3
   } bus_action_type;

   // Class of work found by the front end.
   typedef enum logic [2:0] {
      KIND_NONE,
      KIND_READ,
      KIND_WRITE,
      KIND_SNOOP_RD,
      KIND_SNOOP_KILL
   } kind_type;

   typedef struct packed {
      logic [2:0]  operation;
      logic [31:0] address;
      logic [63:0] write_data;
      logic        shared_elsewhere;
   } req_type;

   typedef struct packed {
      logic [63:0] read_data;
      logic        hit;
      logic [1:0]  new_state;
      logic [1:0]  bus_action;
   } rsp_type;

   // One classified transaction waiting in the queue.
   typedef struct packed {
      kind_type    kind;
      logic [31:0] address;
      logic [63:0] write_data;
      logic        shared;
   } entry_type;

endpackage

// ----- design/msc_front.sv -----
module msc_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  msc_pkg::req_type     req_item,
   output logic                 full,
   output logic                 head_valid,
   output msc_pkg::entry_type   head
);

   msc_pkg::entry_type entry_in;
   msc_pkg::entry_type slot_ff [2];
   logic               wr_ptr_ff;
   logic               rd_ptr_ff;
   logic [1:0]         count_ff;
   logic               pop;

   // Classify the operation code for the back end.
   always_comb begin
      entry_in.address    = req_item.address;
      entry_in.write_data = req_item.write_data;
      entry_in.shared     = req_item.shared_elsewhere;
      unique case (req_item.operation)
         msc_pkg::OP_CPU_READ:  entry_in.kind = msc_pkg::KIND_READ;
         msc_pkg::OP_CPU_WRITE: entry_in.kind = msc_pkg::KIND_WRITE;
         msc_pkg::OP_SNOOP_RD:  entry_in.kind = msc_pkg::KIND_SNOOP_RD;
         msc_pkg::OP_SNOOP_WR:  entry_in.kind = msc_pkg::KIND_SNOOP_KILL;
         msc_pkg::OP_SNOOP_INV: entry_in.kind = msc_pkg::KIND_SNOOP_KILL;
         default:               entry_in.kind = msc_pkg::KIND_NONE;
      endcase
   end

   // The back end drains one entry every cycle that the queue holds one.
   assign pop        = (count_ff != 2'd0);
   assign head_valid = pop;
   assign head       = slot_ff[rd_ptr_ff];
   assign full       = (count_ff == 2'd2);

   // Two-entry queue storage.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= entry_in;
      end
   end

   // Queue pointers and fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         count_ff <= count_ff + {1'b0, push} - {1'b0, pop};
      end
   end

endmodule

// ----- design/msc_back.sv -----
module msc_back #(
   parameter int LINES = 8,
   parameter int RW    = 3,
   parameter int LW    = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 head_valid,
   input  msc_pkg::entry_type   head,
   input  logic [LW-1:0]        limit,
   input  logic                 trim_valid,
   input  logic [LW-1:0]        trim_limit,
   output logic                 rsp_valid,
   output msc_pkg::rsp_type     rsp_item
);

   logic [31:0]             tags_ff  [LINES];
   logic [63:0]             words_ff [LINES];
   msc_pkg::line_state_type state_ff [LINES];
   logic [RW-1:0]           rank_ff  [LINES];
   logic [RW-1:0]           rank_in  [LINES];

   logic [LINES-1:0] hit_vec;
   logic [LINES-1:0] cand;
   logic [LINES-1:0] vic;
   logic             hit_any;
   logic             cand_any;
   logic [RW-1:0]    hit_idx;
   logic [RW-1:0]    vic_idx;
   logic [RW-1:0]    fb_idx;
   logic [RW-1:0]    slot;
   logic [RW-1:0]    slot_rank;
   logic [LW-1:0]    limit_m1;

   logic                    is_cpu;
   logic                    upd_state;
   logic                    upd_word;
   logic                    upd_tag;
   msc_pkg::line_state_type state_new;
   logic [63:0]             word_new;
   msc_pkg::rsp_type        rsp_in;
   msc_pkg::rsp_type        rsp_ff;
   logic                    rsp_valid_ff;

   assign limit_m1 = limit - LW'(1);

   // Tag match and victim search over all lines in parallel.
   always_comb begin
      hit_idx = '0;
      vic_idx = '0;
      fb_idx  = '0;
      for (int i = 0; i < LINES; i++) begin
         hit_vec[i] = (state_ff[i] != msc_pkg::ST_I) && (tags_ff[i] == head.address);
         cand[i]    = (LW'(rank_ff[i]) < limit) && (state_ff[i] == msc_pkg::ST_I);
      end
      for (int i = 0; i < LINES; i++) begin
         vic[i] = cand[i];
         for (int j = 0; j < LINES; j++) begin
            if (cand[j] && (rank_ff[j] > rank_ff[i])) begin
               vic[i] = 1'b0;
            end
         end
      end
      for (int i = 0; i < LINES; i++) begin
         if (hit_vec[i]) begin
            hit_idx = hit_idx | RW'(i);
         end
         if (vic[i]) begin
            vic_idx = vic_idx | RW'(i);
         end
         if (LW'(rank_ff[i]) == limit_m1) begin
            fb_idx = fb_idx | RW'(i);
         end
      end
      hit_any  = |hit_vec;
      cand_any = |cand;
   end

   // Line chosen for this transaction and its current recency rank.
   always_comb begin
      priority if (hit_any) begin
         slot = hit_idx;
      end else if (cand_any) begin
         slot = vic_idx;
      end else begin
         slot = fb_idx;
      end
      slot_rank = rank_ff[slot];
   end

   // Move the chosen line to most recent.
   always_comb begin
      for (int i = 0; i < LINES; i++) begin
         if (RW'(i) == slot) begin
            rank_in[i] = '0;
         end else if (rank_ff[i] < slot_rank) begin
            rank_in[i] = rank_ff[i] + RW'(1);
         end else begin
            rank_in[i] = rank_ff[i];
         end
      end
   end

   // State transitions and the result of the transaction.
   always_comb begin
      is_cpu     = 1'b0;
      upd_state  = 1'b0;
      upd_word   = 1'b0;
      upd_tag    = 1'b0;
      state_new  = msc_pkg::ST_I;
      word_new   = head.write_data;
      rsp_in     = '0;
      unique case (head.kind)
         msc_pkg::KIND_READ: begin
            is_cpu     = 1'b1;
            rsp_in.hit = hit_any;
            if (hit_any) begin
               state_new        = state_ff[slot];
               rsp_in.read_data = words_ff[slot];
            end else begin
               upd_state         = 1'b1;
               upd_word          = 1'b1;
               upd_tag           = 1'b1;
               word_new          = '0;
               state_new         = head.shared ? msc_pkg::ST_S : msc_pkg::ST_E;
               rsp_in.read_data  = '1;
               rsp_in.bus_action = msc_pkg::BUS_RDMISS;
            end
            rsp_in.new_state = state_new;
         end
         msc_pkg::KIND_WRITE: begin
            is_cpu     = 1'b1;
            upd_state  = 1'b1;
            upd_word   = 1'b1;
            upd_tag    = !hit_any;
            state_new  = msc_pkg::ST_M;
            rsp_in.hit = hit_any;
            if (!hit_any) begin
               rsp_in.bus_action = msc_pkg::BUS_WRMISS;
            end else if (state_ff[slot] == msc_pkg::ST_S) begin
               rsp_in.bus_action = msc_pkg::BUS_INV;
            end
            rsp_in.new_state = state_new;
         end
         msc_pkg::KIND_SNOOP_RD: begin
            upd_state        = hit_any;
            state_new        = msc_pkg::ST_S;
            rsp_in.hit       = hit_any;
            rsp_in.new_state = hit_any ? msc_pkg::ST_S : msc_pkg::ST_I;
         end
         msc_pkg::KIND_SNOOP_KILL: begin
            upd_state  = hit_any;
            state_new  = msc_pkg::ST_I;
            rsp_in.hit = hit_any;
         end
         default: begin
         end
      endcase
   end

   // Line states, recency order and the result strobe.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LINES; i++) begin
            state_ff[i] <= msc_pkg::ST_I;
            rank_ff[i]  <= RW'(i);
         end
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= head_valid;
         if (trim_valid) begin
            for (int i = 0; i < LINES; i++) begin
               if (LW'(rank_ff[i]) >= trim_limit) begin
                  state_ff[i] <= msc_pkg::ST_I;
               end
            end
         end else if (head_valid) begin
            if (upd_state) begin
               state_ff[slot] <= state_new;
            end
            if (is_cpu) begin
               rank_ff <= rank_in;
            end
         end
      end
   end

   // Tags, data words and the result payload need no reset.
   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (head_valid && !trim_valid) begin
         if (upd_tag) begin
            tags_ff[slot] <= head.address;
         end
         if (upd_word) begin
            words_ff[slot] <= word_new;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

// ----- design/mesi_snooping_cache_lru.sv -----
// Fully associative snooping cache with MESI line states and LRU replacement.
// Request channel: a transaction (CPU read, CPU write, or a snooped read miss,
// write miss or invalidate) is taken at a rising edge with start high and busy
// low. Every transaction gives exactly one response on rsp_item, shown for one
// cycle with rsp_valid high; the receiver cannot stall it.
// The request is registered in the front-end queue and its response in the
// back-end result register. Throughput: one transaction per cycle. The front
// end classifies requests into a two-entry queue and the back end drains one
// entry per cycle with a tag match, victim search and state update over all
// LINES lines, so busy stays low in normal operation.
// Configuration: csr_wr_en with csr_wr_data writes the line limit (clamped to
// 1..LINES); lines whose recency rank is at or above the new limit are
// invalidated in the same edge. Write it only while no transaction is pending.
// Reset: all lines invalid, line i has recency rank i, line limit 8 (or LINES
// if smaller); no clearing pass is needed.
module mesi_snooping_cache_lru #(
   parameter int LINES = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  msc_pkg::req_type   req_item,
   output logic               rsp_valid,
   output msc_pkg::rsp_type   rsp_item,
   input  logic               csr_wr_en,
   input  logic [3:0]         csr_wr_data
);

   localparam int RW   = (LINES > 1) ? $clog2(LINES) : 1;
   localparam int LW   = $clog2(LINES + 1);
   localparam int CW   = (LW > 4) ? LW : 4;
   localparam int LRST = (LINES < msc_pkg::LIMIT_RESET) ? LINES : msc_pkg::LIMIT_RESET;

   logic               push;
   logic               full;
   logic               head_valid;
   msc_pkg::entry_type head;
   logic [LW-1:0]      limit_ff;
   logic [LW-1:0]      limit_in;

   assign busy = full;
   assign push = start && !full;

   // Clamp the written limit into the range of lines that exist.
   always_comb begin
      priority if (csr_wr_data == 4'd0) begin
         limit_in = LW'(1);
      end else if (CW'(csr_wr_data) > CW'(LINES)) begin
         limit_in = LW'(LINES);
      end else begin
         limit_in = LW'(csr_wr_data);
      end
   end

   // Line limit register.
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LW'(LRST);
      end else if (csr_wr_en) begin
         limit_ff <= limit_in;
      end
   end

   msc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .req_item   (req_item),
      .full       (full),
      .head_valid (head_valid),
      .head       (head)
   );

   msc_back #(
      .LINES (LINES),
      .RW    (RW),
      .LW    (LW)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head       (head),
      .limit      (limit_ff),
      .trim_valid (csr_wr_en),
      .trim_limit (limit_in),
      .rsp_valid  (rsp_valid),
      .rsp_item   (rsp_item)
   );

endmodule
